// ----- rtl/rgbhsv_pkg.sv -----
// shared types, widths and constants for the rgb to hsv converter
`timescale 1ns / 1ps

package rgbhsv_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_W        = 16;
    localparam int SIXTY_UNITS  = 3840;
    localparam int HUE_QB       = 12;
    localparam int SAT_WORK_W   = 2 * CHANNEL_BITS;
    localparam int HUE_WORK_W   = CHANNEL_BITS + HUE_QB;
    localparam int DIV_STAGES   = (HUE_QB > CHANNEL_BITS) ? HUE_QB : CHANNEL_BITS;

    localparam logic signed [HUE_W-1:0] HUE_BASE_RED   = HUE_W'(0);
    localparam logic signed [HUE_W-1:0] HUE_BASE_GREEN = HUE_W'(2 * SIXTY_UNITS);
    localparam logic signed [HUE_W-1:0] HUE_BASE_BLUE  = HUE_W'(4 * SIXTY_UNITS);
    localparam logic signed [HUE_W-1:0] HUE_MIN        = -HUE_W'(SIXTY_UNITS);
    localparam logic signed [HUE_W-1:0] HUE_MAX        = HUE_W'(5 * SIXTY_UNITS);

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } hue_sector_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } rgb_pixel_t;

    typedef struct packed {
        logic signed [HUE_W-1:0] hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } hsv_pixel_t;

    typedef struct packed {
        hue_sector_t             sector;
        logic                    neg;
        logic                    grey;
        logic [CHANNEL_BITS-1:0] brightness;
    } hsv_side_t;

    typedef struct packed {
        logic [SAT_WORK_W-1:0]   sat_work;
        logic [CHANNEL_BITS-1:0] sat_den;
        logic [HUE_WORK_W-1:0]   hue_work;
        logic [CHANNEL_BITS-1:0] hue_den;
        hsv_side_t               side;
    } div_word_t;

endpackage

// ----- rtl/rgbhsv_div_pipe.sv -----
// pipelined restoring divider, one quotient bit per stage for saturation and hue
`timescale 1ns / 1ps

module rgbhsv_div_pipe (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  enable,
    input  logic                  in_valid,
    input  rgbhsv_pkg::div_word_t in_word,
    output logic                  out_valid,
    output rgbhsv_pkg::div_word_t out_word
);
    import rgbhsv_pkg::*;

    function automatic logic [SAT_WORK_W-1:0] sat_step(
        input logic [SAT_WORK_W-1:0]   work,
        input logic [CHANNEL_BITS-1:0] den
    );
        logic [CHANNEL_BITS:0] part;
        logic [CHANNEL_BITS:0] sub;
        logic                  ge;
        part = work[SAT_WORK_W-1:CHANNEL_BITS-1];
        sub  = part - {1'b0, den};
        ge   = (part >= {1'b0, den});
        return {(ge ? sub[CHANNEL_BITS-1:0] : part[CHANNEL_BITS-1:0]),
                work[CHANNEL_BITS-2:0], ge};
    endfunction

    function automatic logic [HUE_WORK_W-1:0] hue_step(
        input logic [HUE_WORK_W-1:0]   work,
        input logic [CHANNEL_BITS-1:0] den
    );
        logic [CHANNEL_BITS:0] part;
        logic [CHANNEL_BITS:0] sub;
        logic                  ge;
        part = work[HUE_WORK_W-1:HUE_QB-1];
        sub  = part - {1'b0, den};
        ge   = (part >= {1'b0, den});
        return {(ge ? sub[CHANNEL_BITS-1:0] : part[CHANNEL_BITS-1:0]),
                work[HUE_QB-2:0], ge};
    endfunction

    div_word_t stage_word [0:DIV_STAGES];
    logic      stage_valid [0:DIV_STAGES];

    assign stage_word[0]  = in_word;
    assign stage_valid[0] = in_valid;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        div_word_t word_next;
        div_word_t word_reg;
        logic      valid_reg;

        always_comb begin
            word_next = stage_word[s];
            if (s < CHANNEL_BITS) begin
                word_next.sat_work = sat_step(stage_word[s].sat_work, stage_word[s].sat_den);
            end
            if (s < HUE_QB) begin
                word_next.hue_work = hue_step(stage_word[s].hue_work, stage_word[s].hue_den);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg <= 1'b0;
            end else if (enable) begin
                valid_reg <= stage_valid[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (enable) begin
                word_reg <= word_next;
            end
        end

        assign stage_word[s+1]  = word_reg;
        assign stage_valid[s+1] = valid_reg;
    end

    assign out_word  = stage_word[DIV_STAGES];
    assign out_valid = stage_valid[DIV_STAGES];

endmodule

// ----- rtl/rgb_to_hsv_converter_unit.sv -----
// rgb to hsv converter top level: input register, max/min, numerators, divider, output register
// throughput: one pixel per cycle unless the result side stalls, set by the one-bit-per-stage divider pipeline
// a stall on the result side freezes every stage; s_ready follows m_ready or an empty output
// reset: synchronous active-low aresetn clears all valid bits, payload registers are not reset
`timescale 1ns / 1ps

module rgb_to_hsv_converter_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  rgbhsv_pkg::rgb_pixel_t s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rgbhsv_pkg::hsv_pixel_t m_data
);
    import rgbhsv_pkg::*;

    logic enable;

    rgb_pixel_t pix_reg;
    logic       pix_valid_reg;

    logic [CHANNEL_BITS-1:0] mx_next, mn_next, delta_next, diff_next;
    logic [CHANNEL_BITS-1:0] op_a, op_b;
    hue_sector_t             sector_next;
    logic                    neg_next;
    logic [CHANNEL_BITS-1:0] mx_reg, delta_reg, diff_reg;
    hue_sector_t             sector_reg;
    logic                    neg_reg;
    logic                    calc_valid_reg;

    div_word_t div_next, div_reg, div_out;
    logic      div_valid_reg, div_out_valid;

    logic signed [HUE_W-1:0] hue_base, hue_frac;
    hsv_pixel_t              out_next, out_reg;
    logic                    out_valid_reg;

    assign enable  = !out_valid_reg || m_ready;
    assign s_ready = enable;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_valid_reg  <= 1'b0;
            calc_valid_reg <= 1'b0;
            div_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (enable) begin
            pix_valid_reg  <= s_valid;
            calc_valid_reg <= pix_valid_reg;
            div_valid_reg  <= calc_valid_reg;
            out_valid_reg  <= div_out_valid;
        end
    end

    // max, min, delta, hue sector selection and the sector difference with its sign
    always_comb begin
        mx_next = pix_reg.red;
        mn_next = pix_reg.red;
        if (pix_reg.green > mx_next) begin
            mx_next = pix_reg.green;
        end
        if (pix_reg.blue > mx_next) begin
            mx_next = pix_reg.blue;
        end
        if (pix_reg.green < mn_next) begin
            mn_next = pix_reg.green;
        end
        if (pix_reg.blue < mn_next) begin
            mn_next = pix_reg.blue;
        end
        delta_next = mx_next - mn_next;
        if (mx_next == pix_reg.red && mx_next != pix_reg.green) begin
            sector_next = SECTOR_RED;
            op_a        = pix_reg.green;
            op_b        = pix_reg.blue;
        end else if (mx_next == pix_reg.green && mx_next != pix_reg.blue) begin
            sector_next = SECTOR_GREEN;
            op_a        = pix_reg.blue;
            op_b        = pix_reg.red;
        end else begin
            sector_next = SECTOR_BLUE;
            op_a        = pix_reg.red;
            op_b        = pix_reg.green;
        end
        neg_next  = (op_a < op_b);
        diff_next = neg_next ? (op_b - op_a) : (op_a - op_b);
    end

    // numerators, guarded divisors and side information
    always_comb begin
        div_next.sat_work        = {delta_reg, CHANNEL_BITS'(0)} - SAT_WORK_W'(delta_reg);
        div_next.sat_den         = (mx_reg == '0) ? CHANNEL_BITS'(1) : mx_reg;
        div_next.hue_work        = HUE_WORK_W'(diff_reg) * HUE_WORK_W'(SIXTY_UNITS);
        div_next.hue_den         = (delta_reg == '0) ? CHANNEL_BITS'(1) : delta_reg;
        div_next.side.sector     = sector_reg;
        div_next.side.neg        = neg_reg;
        div_next.side.grey       = (delta_reg == '0);
        div_next.side.brightness = mx_reg;
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            pix_reg    <= s_data;
            mx_reg     <= mx_next;
            delta_reg  <= delta_next;
            diff_reg   <= diff_next;
            sector_reg <= sector_next;
            neg_reg    <= neg_next;
            div_reg    <= div_next;
            out_reg    <= out_next;
        end
    end

    rgbhsv_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (enable),
        .in_valid  (div_valid_reg),
        .in_word   (div_reg),
        .out_valid (div_out_valid),
        .out_word  (div_out)
    );

    // hue assembly and output pixel
    always_comb begin
        case (div_out.side.sector)
            SECTOR_RED:   hue_base = HUE_BASE_RED;
            SECTOR_GREEN: hue_base = HUE_BASE_GREEN;
            SECTOR_BLUE:  hue_base = HUE_BASE_BLUE;
            default:      hue_base = HUE_BASE_RED;
        endcase
        hue_frac = $signed(HUE_W'(div_out.hue_work[HUE_QB-1:0]));
        if (div_out.side.grey) begin
            out_next.hue = '0;
        end else if (div_out.side.neg) begin
            out_next.hue = hue_base - hue_frac;
        end else begin
            out_next.hue = hue_base + hue_frac;
        end
        out_next.saturation = div_out.sat_work[CHANNEL_BITS-1:0];
        out_next.brightness = div_out.side.brightness;
    end

endmodule

// ----- rtl/rgbhsv_checker.sv -----
// port-level checker for the rgb to hsv converter and its bind
`timescale 1ns / 1ps

module rgbhsv_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input rgbhsv_pkg::hsv_pixel_t m_data
);
    import rgbhsv_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a stalled output holds s_ready low
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input ready during output stall");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // zero saturation means grey, so hue is zero
    a_grey_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturation == '0 |-> m_data.hue == '0)
        else $error("nonzero hue on grey pixel");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.hue >= HUE_MIN && m_data.hue <= HUE_MAX)
        else $error("hue out of range");

endmodule

bind rgb_to_hsv_converter_unit rgbhsv_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- test/tb_rgb_to_hsv_converter_unit.sv -----
// testbench for the rgb to hsv converter: directed and random pixels checked against a predictor
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_unit;
    import rgbhsv_pkg::*;

    localparam int CMAX = (1 << CHANNEL_BITS) - 1;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    rgb_pixel_t s_data;
    logic       m_valid;
    logic       m_ready;
    hsv_pixel_t m_data;

    hsv_pixel_t hsv_expected[$];
    int         mismatches = 0;

    rgb_to_hsv_converter_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic hsv_pixel_t predict_hsv(rgb_pixel_t px);
        int          r;
        int          g;
        int          b;
        int          mx;
        int          mn;
        int          delta;
        int          hue;
        int          diff;
        hue_sector_t sector;
        hsv_pixel_t  hsv;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = (r > g) ? r : g;
        mx = (b > mx) ? b : mx;
        mn = (r < g) ? r : g;
        mn = (b < mn) ? b : mn;
        delta = mx - mn;
        hue = 0;
        if (delta > 0) begin
            if (mx == r && mx != g) begin
                sector = SECTOR_RED;
            end else if (mx == g && mx != b) begin
                sector = SECTOR_GREEN;
            end else begin
                sector = SECTOR_BLUE;
            end
            case (sector)
                SECTOR_RED: begin
                    diff = g - b;
                    hue = int'(HUE_BASE_RED);
                end
                SECTOR_GREEN: begin
                    diff = b - r;
                    hue = int'(HUE_BASE_GREEN);
                end
                default: begin
                    diff = r - g;
                    hue = int'(HUE_BASE_BLUE);
                end
            endcase
            // int division truncates toward zero
            hue = hue + (SIXTY_UNITS * diff) / delta;
        end
        hsv.hue        = HUE_W'(hue);
        hsv.saturation = (mx > 0) ? CHANNEL_BITS'((CMAX * delta) / mx) : '0;
        hsv.brightness = CHANNEL_BITS'(mx);
        return hsv;
    endfunction

    task automatic send_pixel(input rgb_pixel_t px);
        s_valid <= 1'b1;
        s_data  <= px;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        hsv_expected.push_back(predict_hsv(px));
    endtask

    task automatic send_rgb(input int r, input int g, input int b);
        rgb_pixel_t px;
        px.red   = CHANNEL_BITS'(r);
        px.green = CHANNEL_BITS'(g);
        px.blue  = CHANNEL_BITS'(b);
        send_pixel(px);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (hsv_expected.size() != 0) @(posedge aclk);
    endtask

    function automatic rgb_pixel_t random_pixel();
        rgb_pixel_t px;
        int         level;
        px = rgb_pixel_t'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                px.green = px.red;
                px.blue  = px.red;
            end
            1: px.green = px.red;
            2: px.blue  = px.green;
            3: px.blue  = px.red;
            4: begin
                level    = $urandom_range(0, 3);
                px.red   = CHANNEL_BITS'($urandom_range(0, level));
                px.green = CHANNEL_BITS'($urandom_range(0, level));
                px.blue  = CHANNEL_BITS'($urandom_range(0, level));
            end
            5: begin
                px.red   = CHANNEL_BITS'(CMAX - $urandom_range(0, 2));
                px.green = CHANNEL_BITS'(CMAX - $urandom_range(0, 2));
                px.blue  = CHANNEL_BITS'(CMAX - $urandom_range(0, 2));
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic test_extremes();
        send_rgb(0, 0, 0);
        send_rgb(CMAX, CMAX, CMAX);
        send_rgb(128, 128, 128);
        send_rgb(1, 1, 1);
        send_rgb(CMAX, 0, 0);
        send_rgb(0, CMAX, 0);
        send_rgb(0, 0, CMAX);
        send_rgb(1, 0, 0);
        send_rgb(CMAX, CMAX - 1, CMAX - 1);
        send_rgb(1, 1, 0);
    endtask

    task automatic test_sectors();
        send_rgb(CMAX, 100, 50);
        send_rgb(CMAX, 0, 100);
        send_rgb(50, CMAX, 100);
        send_rgb(100, CMAX, 0);
        send_rgb(100, 50, CMAX);
        send_rgb(0, 100, CMAX);
    endtask

    task automatic test_ties();
        send_rgb(CMAX, CMAX, 0);
        send_rgb(0, CMAX, CMAX);
        send_rgb(CMAX, 0, CMAX);
        send_rgb(200, 200, 199);
        send_rgb(77, 90, 90);
        send_rgb(5, 0, 5);
    endtask

    task automatic test_drain_pause();
        repeat (8) send_pixel(random_pixel());
        wait_drained();
        repeat (8) send_pixel(random_pixel());
    endtask

    task automatic test_random_stream(input int count);
        int burst;
        burst = 0;
        repeat (count) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) begin
                    idle_sender($urandom_range(1, 12));
                end
            end
            send_pixel(random_pixel());
            burst--;
        end
    endtask

    // result side stalls in phases of its own
    initial begin
        int stall_mode;
        int cyc;
        m_ready <= 1'b0;
        stall_mode = 0;
        cyc = 0;
        forever begin
            @(posedge aclk);
            if (cyc % 50 == 0) begin
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= cyc[2];
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
            cyc++;
        end
    end

    always @(posedge aclk) begin
        hsv_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (hsv_expected.size() == 0) begin
                $error("unexpected result transaction: hue %0d", m_data.hue);
                mismatches++;
            end else begin
                want = hsv_expected.pop_front();
                if (m_data.hue !== want.hue) begin
                    $error("hue mismatch: expected %0d, got %0d", want.hue, m_data.hue);
                    mismatches++;
                end
                if (m_data.saturation !== want.saturation) begin
                    $error("saturation mismatch: expected %0d, got %0d",
                           want.saturation, m_data.saturation);
                    mismatches++;
                end
                if (m_data.brightness !== want.brightness) begin
                    $error("brightness mismatch: expected %0d, got %0d",
                           want.brightness, m_data.brightness);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_sectors();
        test_ties();
        test_drain_pause();
        test_random_stream(410);

        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
